FILE: src/ecgd_pkg.sv
// Package with shared types and constants of the ECG beat wave delineator.
package ecgd_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = ADDR_W + 1;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ONSET_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATE_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_END = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_P_NEAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_P_FAR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_T_END = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_P_SLOPE = 3'd6;

    typedef struct packed {
        logic [1:0] kind;
        logic signed [15:0] sample;
        logic [11:0] r_index;
    } t_in_item;

    typedef struct packed {
        logic [11:0] qrs_onset;
        logic [11:0] qrs_offset;
        logic [11:0] p_onset;
        logic [11:0] t_peak;
        logic [11:0] t_end;
    } t_out_item;

endpackage

FILE: src/ecgd_ram.sv
// Generic single-port synchronous RAM with registered read.
module ecgd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: src/ecg_beat_wave_delineator.sv
// Top level of the ECG beat wave delineator: sample store and query sequencer.
// An append or clear is taken while idle and does not raise busy. A query keeps busy high
// while its five scans read samples through the single RAM port, each with a request and a wait state.
// The result strobe is high for one cycle, in the cycle in which busy falls; it cannot be held off.
// Synchronous active-low reset empties the store and loads the register defaults.
module ecg_beat_wave_delineator import ecgd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output logic                  o_valid,
    output t_out_item             o_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_REQ, S_WAIT, S_USE, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        P_ONSET, P_OFFSET, P_PON, P_TPEAK, P_TEND
    } t_phase;

    localparam int IW = 20;
    localparam logic signed [IW-1:0] ONE = IW'(1);
    localparam logic signed [IW-1:0] TWO = IW'(2);

    t_state r_state;
    t_phase r_phase;
    logic [CNT_W-1:0] r_count;
    logic [9:0] r_onset_win, r_late, r_off_end, r_p_near, r_p_far;
    logic [10:0] r_t_end_win;
    logic signed [15:0] r_p_slope;

    logic signed [IW-1:0] r_r, r_i, r_stop, r_mark, r_best_idx;
    logic signed [IW-1:0] r_onset, r_offset, r_pon;
    logic signed [SAMPLE_W:0] r_best;
    logic signed [SAMPLE_W-1:0] r_prev, r_bestv;
    logic r_have_prev, r_found;

    logic ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic signed [SAMPLE_W-1:0] cur;
    logic signed [SAMPLE_W:0] slope;
    logic signed [IW-1:0] n_s, last_s, lo_s, hi_s;

    assign ram_we = (r_state == S_IDLE) && start && (i_item.kind == KIND_APPEND)
        && (r_count < CNT_W'(STORE_DEPTH));
    assign ram_addr = ram_we ? r_count[ADDR_W-1:0] : r_i[ADDR_W-1:0];
    assign busy = (r_state != S_IDLE);

    ecgd_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(i_item.sample), .o_rdata(ram_rdata)
    );

    assign cur = ram_rdata;
    assign n_s = IW'(r_count);
    assign last_s = (r_count == '0) ? '0 : n_s - ONE;

    function automatic logic signed [IW-1:0] clampl(input logic signed [IW-1:0] x,
                                                     input logic signed [IW-1:0] l);
        return (x < l) ? x : l;
    endfunction

    function automatic logic signed [IW-1:0] max0(input logic signed [IW-1:0] x);
        return x[IW-1] ? '0 : x;
    endfunction

    // Slope between the current sample (index r_i, read descending) and the one above.
    assign slope = (SAMPLE_W+1)'(r_prev) - (SAMPLE_W+1)'(cur);

    always_comb begin
        lo_s = '0;
        hi_s = '0;
        unique case (r_phase)
            P_OFFSET: begin
                lo_s = clampl(r_r + IW'(r_late), last_s);
                hi_s = clampl(r_r + IW'(r_off_end), last_s);
            end
            P_TPEAK: begin
                lo_s = clampl(r_r + IW'(r_late), last_s);
                hi_s = clampl(r_r + IW'(r_t_end_win), last_s);
            end
            default: begin
                lo_s = '0;
                hi_s = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_ONSET;
            r_count <= '0;
            o_valid <= 1'b0;
            r_onset_win <= 10'd54;
            r_late <= 10'd72;
            r_off_end <= 10'd144;
            r_p_near <= 10'd28;
            r_p_far <= 10'd108;
            r_t_end_win <= 11'd324;
            r_p_slope <= 16'sd20;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ONSET_WINDOW: r_onset_win <= i_cfg_data[9:0];
                    CFG_LATE_START: r_late <= i_cfg_data[9:0];
                    CFG_OFFSET_END: r_off_end <= i_cfg_data[9:0];
                    CFG_P_NEAR: r_p_near <= i_cfg_data[9:0];
                    CFG_P_FAR: r_p_far <= i_cfg_data[9:0];
                    CFG_T_END: r_t_end_win <= i_cfg_data[10:0];
                    CFG_P_SLOPE: r_p_slope <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_item.kind == KIND_APPEND) begin
                            if (r_count < CNT_W'(STORE_DEPTH)) r_count <= r_count + 1'b1;
                        end else if (i_item.kind == KIND_CLEAR) begin
                            r_count <= '0;
                        end else if (i_item.kind == KIND_QUERY) begin
                            r_r <= IW'(i_item.r_index);
                            r_phase <= P_ONSET;
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_have_prev <= 1'b0;
                    r_found <= 1'b0;
                    r_best <= '0;
                    r_state <= S_REQ;
                    unique case (r_phase)
                        P_ONSET: begin
                            r_mark <= r_r;
                            r_i <= clampl(r_r, n_s) - ONE;
                            r_stop <= max0(r_r - IW'(r_onset_win));
                            if (clampl(r_r, n_s) - ONE < max0(r_r - IW'(r_onset_win)))
                                r_state <= S_USE;
                        end
                        P_PON: begin
                            r_mark <= max0(r_r - IW'(r_p_near));
                            r_i <= clampl(max0(r_r - IW'(r_p_near)), n_s) - ONE;
                            r_stop <= max0(r_r - IW'(r_p_far));
                            if (clampl(max0(r_r - IW'(r_p_near)), n_s) - ONE
                                < max0(r_r - IW'(r_p_far)))
                                r_state <= S_USE;
                        end
                        P_OFFSET, P_TPEAK: begin
                            r_best_idx <= (lo_s >= hi_s) ? hi_s : lo_s;
                            r_i <= lo_s;
                            r_stop <= hi_s;
                            if (lo_s >= hi_s) r_state <= S_USE;
                        end
                        default: begin
                            r_mark <= r_best_idx;
                            r_i <= r_best_idx;
                            if (r_best_idx >= n_s - ONE) r_state <= S_USE;
                        end
                    endcase
                end
                S_REQ: r_state <= S_WAIT;
                S_WAIT: begin
                    r_state <= S_REQ;
                    r_have_prev <= 1'b1;
                    r_prev <= cur;
                    unique case (r_phase)
                        P_ONSET: begin
                            if (r_have_prev && slope < r_best) begin
                                r_best <= slope;
                                r_mark <= r_i + ONE;
                            end
                            if (r_i <= r_stop) r_state <= S_USE;
                            else r_i <= r_i - ONE;
                        end
                        P_PON: begin
                            if (r_have_prev) begin
                                if (slope < (SAMPLE_W+1)'(r_p_slope)) begin
                                    r_mark <= r_i + ONE;
                                    r_found <= 1'b1;
                                end else if (r_found) begin
                                    r_mark <= r_i + ONE;
                                    r_state <= S_USE;
                                end
                            end
                            if (r_i <= r_stop) r_state <= S_USE;
                            else r_i <= r_i - ONE;
                        end
                        P_OFFSET, P_TPEAK: begin
                            if (!r_have_prev || cur > r_bestv) begin
                                r_bestv <= cur;
                                r_best_idx <= r_i;
                            end
                            if (r_i + ONE >= r_stop) r_state <= S_USE;
                            else r_i <= r_i + ONE;
                        end
                        default: begin
                            if (!r_have_prev || cur < r_bestv) begin
                                r_bestv <= cur;
                                r_mark <= r_i;
                            end
                            if (r_have_prev && r_prev < cur) r_state <= S_USE;
                            else if (r_i >= n_s - TWO) r_state <= S_USE;
                            else r_i <= r_i + ONE;
                        end
                    endcase
                end
                S_USE: begin
                    r_state <= S_SETUP;
                    unique case (r_phase)
                        P_ONSET: begin r_onset <= r_mark; r_phase <= P_OFFSET; end
                        P_OFFSET: begin r_offset <= r_best_idx; r_phase <= P_PON; end
                        P_PON: begin r_pon <= r_mark; r_phase <= P_TPEAK; end
                        P_TPEAK: r_phase <= P_TEND;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_item.qrs_onset <= r_onset[11:0];
                    o_item.qrs_offset <= r_offset[11:0];
                    o_item.p_onset <= r_pon[11:0];
                    o_item.t_peak <= r_best_idx[11:0];
                    o_item.t_end <= r_mark[11:0];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: dv/tb_ecg_beat_wave_delineator.sv
// Testbench for the ECG beat wave delineator with a self-checking scoreboard.
`timescale 1ns / 1ps

module tb_ecg_beat_wave_delineator import ecgd_pkg::*; ();

    localparam int CYCLE_LIMIT = 3000000;

    class delineation_scoreboard;
        logic [15:0] wave_mem [STORE_DEPTH];
        int sample_count;
        int onset_win, late_start, offset_end, p_near, p_far, t_end_win, p_slope;
        t_out_item marks_due[$];

        function new();
            sample_count = 0;
            onset_win = 54;
            late_start = 72;
            offset_end = 144;
            p_near = 28;
            p_far = 108;
            t_end_win = 324;
            p_slope = 20;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ONSET_WINDOW: onset_win = val[9:0];
                CFG_LATE_START: late_start = val[9:0];
                CFG_OFFSET_END: offset_end = val[9:0];
                CFG_P_NEAR: p_near = val[9:0];
                CFG_P_FAR: p_far = val[9:0];
                CFG_T_END: t_end_win = val[10:0];
                CFG_P_SLOPE: p_slope = int'($signed(val));
                default: ;
            endcase
        endfunction

        function int level(int i);
            if (i < 0 || i >= sample_count) return 0;
            return int'($signed(wave_mem[i]));
        endfunction

        function int last_bound(int x);
            int lim;
            lim = (sample_count == 0) ? 0 : sample_count - 1;
            return (x < lim) ? x : lim;
        endfunction

        function int first_peak(int a, int b);
            int pk;
            if (a >= b) return b;
            pk = a;
            for (int i = a + 1; i < b; i++)
                if (level(i) > level(pk)) pk = i;
            return pk;
        endfunction

        function t_out_item delineate(int r);
            t_out_item m;
            int onset, steep, lo, hi, e, b, ponset, tpeak, tend, s;
            bit hit;
            onset = r;
            steep = 0;
            lo = (r - onset_win < 0) ? 0 : r - onset_win;
            hi = ((r < sample_count) ? r : sample_count) - 1;
            for (int i = hi; i > lo; i--) begin
                s = level(i) - level(i - 1);
                if (s < steep) begin
                    steep = s;
                    onset = i;
                end
            end
            e = (r - p_near < 0) ? 0 : r - p_near;
            b = (r - p_far < 0) ? 0 : r - p_far;
            ponset = e;
            hit = 0;
            hi = ((e < sample_count) ? e : sample_count) - 1;
            for (int i = hi; i > b; i--) begin
                s = level(i) - level(i - 1);
                if (s < p_slope) begin
                    ponset = i;
                    hit = 1;
                end else if (hit) begin
                    ponset = i;
                    break;
                end
            end
            tpeak = first_peak(last_bound(r + late_start), last_bound(r + t_end_win));
            tend = tpeak;
            for (int i = tpeak; i < sample_count - 1; i++) begin
                if (level(i) < level(tend)) tend = i;
                if (level(i) < level(i + 1)) break;
            end
            m.qrs_onset = onset[11:0];
            m.qrs_offset = 12'(first_peak(last_bound(r + late_start),
                                          last_bound(r + offset_end)));
            m.p_onset = ponset[11:0];
            m.t_peak = tpeak[11:0];
            m.t_end = tend[11:0];
            return m;
        endfunction

        function void note_beat(t_in_item it);
            case (it.kind)
                KIND_APPEND: if (sample_count < STORE_DEPTH) begin
                    wave_mem[sample_count] = it.sample;
                    sample_count++;
                end
                KIND_CLEAR: sample_count = 0;
                KIND_QUERY: marks_due = {marks_due, delineate(int'(it.r_index))};
                default: ;
            endcase
        endfunction

        function string check_marks(t_out_item got);
            t_out_item want;
            string msg;
            if (marks_due.size() == 0) return "result with no query pending";
            want = marks_due.pop_front();
            msg = "";
            if (got.qrs_onset !== want.qrs_onset)
                msg = {msg, $sformatf(" qrs_onset %0d/%0d", got.qrs_onset, want.qrs_onset)};
            if (got.qrs_offset !== want.qrs_offset)
                msg = {msg, $sformatf(" qrs_offset %0d/%0d", got.qrs_offset, want.qrs_offset)};
            if (got.p_onset !== want.p_onset)
                msg = {msg, $sformatf(" p_onset %0d/%0d", got.p_onset, want.p_onset)};
            if (got.t_peak !== want.t_peak)
                msg = {msg, $sformatf(" t_peak %0d/%0d", got.t_peak, want.t_peak)};
            if (got.t_end !== want.t_end)
                msg = {msg, $sformatf(" t_end %0d/%0d", got.t_end, want.t_end)};
            return msg;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_item i_item = '0;
    logic o_valid;
    t_out_item o_item;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    delineation_scoreboard sb = new();
    int mismatches = 0;
    int cycles = 0;
    int wave_level = 0;

    ecg_beat_wave_delineator dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_valid(o_valid),
        .o_item(o_item),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report(string msg);
        mismatches++;
        $display("mismatch at cycle %0d:%s", cycles, msg);
    endtask

    always @(posedge i_clk) begin
        string msg;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else if (i_rst_n && o_valid) begin
            msg = sb.check_marks(o_item);
            if (msg != "") report(msg);
        end
    end

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic random_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return;
        if (p < 90) pause($urandom_range(1, 3));
        else pause($urandom_range(10, 40));
    endtask

    task automatic send_beat(t_in_item it);
        start <= 1'b1;
        i_item <= it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_beat(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.marks_due.size() != 0 || busy);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_regs(int v[7]);
        for (int k = 0; k < 7; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_IDX_W'(k);
            i_cfg_data <= CFG_DATA_W'(v[k]);
            sb.set_reg(CFG_IDX_W'(k), CFG_DATA_W'(v[k]));
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item make_beat(logic [1:0] kind, int smp, int r);
        t_in_item it;
        it.kind = kind;
        it.sample = smp[15:0];
        it.r_index = r[11:0];
        return it;
    endfunction

    function automatic int next_sample();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) wave_level += int'($urandom_range(0, 600)) - 300;
        else if (p < 80) wave_level -= int'($urandom_range(500, 4000));
        else if (p < 90) wave_level += int'($urandom_range(500, 4000));
        else wave_level = int'($signed(16'($urandom)));
        if (wave_level > 32767) wave_level = 32767;
        if (wave_level < -32768) wave_level = -32768;
        return wave_level;
    endfunction

    function automatic int query_index();
        int p;
        p = $urandom_range(0, 99);
        if (p < 75) return $urandom_range(0, sb.sample_count + 20);
        if (p < 90) return $urandom_range(0, 4095);
        return (p < 95) ? 0 : 4095;
    endfunction

    initial begin
        int regs[7];
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(make_beat(KIND_QUERY, 0, 0));
        send_beat(make_beat(KIND_QUERY, -1, 4095));
        send_beat(make_beat(2'd3, 0, 0));
        send_beat(make_beat(KIND_APPEND, 32767, 0));
        send_beat(make_beat(KIND_APPEND, -32768, 4095));
        send_beat(make_beat(KIND_APPEND, 0, 0));
        send_beat(make_beat(KIND_APPEND, -1, 0));
        send_beat(make_beat(KIND_APPEND, 1, 0));
        send_beat(make_beat(KIND_APPEND, 16'h5555, 0));
        send_beat(make_beat(KIND_QUERY, 0, 3));
        send_beat(make_beat(KIND_QUERY, 0, 5));
        send_beat(make_beat(KIND_QUERY, 0, 4095));
        send_beat(make_beat(KIND_CLEAR, 0, 0));
        send_beat(make_beat(KIND_QUERY, 0, 2));

        send_beat(make_beat(KIND_QUERY, 0, 4095));
        send_beat(make_beat(KIND_QUERY, 0, 2000));
        send_beat(make_beat(KIND_QUERY, 0, 60));
        send_beat(make_beat(KIND_CLEAR, 0, 0));

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            if (ph == 0) regs = '{54, 72, 144, 28, 108, 324, 20};
            else if (ph == 1) regs = '{0, 0, 0, 0, 0, 0, -32768};
            else if (ph == 2) regs = '{1023, 1023, 1023, 1023, 1023, 2047, 32767};
            else if (ph == 3) regs = '{1023, 0, 1023, 0, 1023, 2047, 0};
            else begin
                for (int k = 0; k < 6; k++)
                    regs[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 150);
                if ($urandom_range(0, 1) == 1) regs[5] = $urandom_range(0, 2047);
                regs[6] = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 400)) - 200
                                                      : int'($signed(16'($urandom)));
            end
            write_regs(regs);
            send_beat(make_beat(KIND_CLEAR, $urandom, $urandom));
            len = $urandom_range(50, 120);
            for (int i = 0; i < len; i++) begin
                random_gap();
                send_beat(make_beat(KIND_APPEND, next_sample(), $urandom));
                if ($urandom_range(0, 14) == 0) begin
                    if (ph == 5) drain();
                    send_beat(make_beat(KIND_QUERY, $urandom, query_index()));
                end
                if ($urandom_range(0, 49) == 0)
                    send_beat(make_beat(2'd3, $urandom, $urandom));
            end
            repeat (3) begin
                random_gap();
                send_beat(make_beat(KIND_QUERY, $urandom, query_index()));
            end
        end

        drain();
        if (mismatches == 0 && sb.marks_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/ecgd_pkg.sv
src/ecgd_ram.sv
src/ecg_beat_wave_delineator.sv
dv/tb_ecg_beat_wave_delineator.sv
